/* rtl/rpn_pkg.sv */
`default_nettype none

package rpn_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int VAR_COUNT   = 32;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 5;

  // The stack pointer has to hold the depth itself, the address only the entries.
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int VA_W   = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
  localparam int CNT_W  = $clog2(DATA_W);

  typedef enum logic [1:0] {
    ACT_LOAD       = 2'd0,
    ACT_PUSH_CONST = 2'd1,
    ACT_PUSH_VAR   = 2'd2,
    ACT_APPLY      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CALC,
    S_WAIT,
    S_EMIT
  } seq_state_e;

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_FIN
  } alu_state_e;

  typedef struct packed {
    action_e                    action;
    logic [IDX_W-1:0]           var_index;
    logic signed [DATA_W-1:0]   operand_value;
    op_e                        operator_code;
    logic                       last;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    status_e                  status;
  } out_t;

  typedef struct packed {
    logic              start;
    op_e               op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } emit_t;

endpackage

`default_nettype wire

/* rtl/rpn_alu.sv */
`default_nettype none

module rpn_alu
  import rpn_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire alu_req_t req_i,
  output alu_rsp_t      rsp_o
);

  alu_state_e state_q, state_d;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] dvd_q, dvd_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] dsr_q, dsr_d;
  logic              neg_q, neg_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic              done_q, done_d;

  logic [DATA_W-1:0] mag_a, mag_b, simple_res;
  logic [DATA_W:0]   rem_sh, diff;
  logic              is_div, div_by_zero;

  assign mag_a       = req_i.a[DATA_W-1] ? (DATA_W'(0) - req_i.a) : req_i.a;
  assign mag_b       = req_i.b[DATA_W-1] ? (DATA_W'(0) - req_i.b) : req_i.b;
  assign is_div      = (req_i.op == OP_DIV);
  assign div_by_zero = (req_i.b == '0);

  always_comb begin
    case (req_i.op)
      OP_ADD:  simple_res = req_i.a + req_i.b;
      OP_SUB:  simple_res = req_i.a - req_i.b;
      OP_MUL:  simple_res = req_i.a * req_i.b;
      default: simple_res = '0;
    endcase
  end

  // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
  assign rem_sh = {rem_q, dvd_q[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dsr_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start && is_div && !div_by_zero) begin
          state_d = A_DIV;
        end
      end
      A_DIV: begin
        if (cnt_q == CNT_W'(DATA_W - 1)) begin
          state_d = A_FIN;
        end
      end
      A_FIN:   state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    neg_d  = neg_q;
    res_d  = res_q;
    done_d = 1'b0;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          if (is_div && !div_by_zero) begin
            dvd_d = mag_a;
            dsr_d = mag_b;
            rem_d = '0;
            cnt_d = '0;
            neg_d = req_i.a[DATA_W-1] ^ req_i.b[DATA_W-1];
          end else begin
            res_d  = simple_res;
            done_d = 1'b1;
          end
        end
      end
      A_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (!diff[DATA_W]) begin
          rem_d = diff[DATA_W-1:0];
          dvd_d = {dvd_q[DATA_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[DATA_W-1:0];
          dvd_d = {dvd_q[DATA_W-2:0], 1'b0};
        end
      end
      A_FIN: begin
        res_d  = neg_q ? (DATA_W'(0) - dvd_q) : dvd_q;
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

`default_nettype wire

/* rtl/rpn_seq.sv */
`default_nettype none

module rpn_seq
  import rpn_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_t      in_data_i,
  output alu_req_t      alu_req_o,
  input  wire alu_rsp_t alu_rsp_i,
  output emit_t         emit_o,
  input  wire logic     emit_ready_i
);

  seq_state_e state_q, state_d;

  logic [SP_W-1:0]   sp_q, sp_d;
  status_e           err_q, err_d;
  in_t               req_q;
  logic [DATA_W-1:0] top_q, top_d;

  logic [DATA_W-1:0] stk_q [STACK_DEPTH];
  logic [DATA_W-1:0] rd_a_q, rd_b_q;
  logic [DATA_W-1:0] var_q [VAR_COUNT];
  logic [VAR_COUNT-1:0] vval_q;
  logic [DATA_W-1:0] vrd_q;
  logic              vrd_ok_q;

  logic              wr_en, rd_en, vwr_en, vrd_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data, fetch_val, push_val;
  logic              flag_en;
  status_e           flag_code;
  logic              sp_full, sp_lt2, in_acc, vin_range, do_push;
  logic [SP_W-1:0]   sp_m1, sp_m2;
  logic [VA_W-1:0]   vaddr;
  status_e           emit_status;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign sp_full    = (sp_q >= SP_W'(STACK_DEPTH));
  assign sp_lt2     = (sp_q < SP_W'(2));
  assign sp_m1      = sp_q - SP_W'(1);
  assign sp_m2      = sp_q - SP_W'(2);
  assign vaddr      = VA_W'(in_data_i.var_index);
  assign vin_range  = (int'(in_data_i.var_index) < VAR_COUNT);
  assign fetch_val  = vrd_ok_q ? vrd_q : '0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.action)
            ACT_LOAD:       state_d = S_IDLE;
            ACT_PUSH_CONST: state_d = in_data_i.last ? S_EMIT : S_IDLE;
            ACT_PUSH_VAR:   state_d = S_FETCH;
            ACT_APPLY: begin
              if (sp_lt2) begin
                state_d = in_data_i.last ? S_EMIT : S_IDLE;
              end else begin
                state_d = S_CALC;
              end
            end
            default:        state_d = S_IDLE;
          endcase
        end
      end
      S_FETCH: state_d = req_q.last ? S_EMIT : S_IDLE;
      S_CALC:  state_d = S_WAIT;
      S_WAIT: begin
        if (alu_rsp_i.done) begin
          state_d = req_q.last ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (emit_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = sp_q[ADDR_W-1:0];
    wr_data   = '0;
    rd_en     = 1'b0;
    vwr_en    = 1'b0;
    vrd_en    = 1'b0;
    sp_d      = sp_q;
    top_d     = top_q;
    flag_en   = 1'b0;
    flag_code = ST_OK;
    do_push   = 1'b0;
    push_val  = in_data_i.operand_value;
    alu_req_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.action)
            ACT_LOAD:       vwr_en = vin_range;
            ACT_PUSH_CONST: do_push = 1'b1;
            ACT_PUSH_VAR:   vrd_en = 1'b1;
            ACT_APPLY: begin
              if (sp_lt2) begin
                flag_en   = 1'b1;
                flag_code = ST_UNDER;
              end else begin
                rd_en = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        do_push  = 1'b1;
        push_val = fetch_val;
      end
      S_CALC: begin
        alu_req_o.start = 1'b1;
        alu_req_o.op    = req_q.operator_code;
        alu_req_o.a     = rd_a_q;
        alu_req_o.b     = rd_b_q;
      end
      S_WAIT: begin
        if (alu_rsp_i.done) begin
          wr_en   = 1'b1;
          wr_addr = sp_m2[ADDR_W-1:0];
          wr_data = alu_rsp_i.result;
          sp_d    = sp_m1;
          top_d   = alu_rsp_i.result;
          if ((req_q.operator_code == OP_DIV) && (rd_b_q == '0)) begin
            flag_en   = 1'b1;
            flag_code = ST_DIVZ;
          end
        end
      end
      S_EMIT: begin
        if (emit_ready_i) begin
          sp_d = '0;
        end
      end
      default: ;
    endcase

    // A push onto a full stack is dropped and only flags overflow.
    if (do_push) begin
      if (sp_full) begin
        flag_en   = 1'b1;
        flag_code = ST_OVER;
      end else begin
        wr_en   = 1'b1;
        wr_data = push_val;
        sp_d    = sp_q + SP_W'(1);
        top_d   = push_val;
      end
    end
  end

  // When no error was flagged, the token just finished wrote the top entry into top_q.
  assign emit_status = (err_q != ST_OK) ? err_q : ((sp_q == '0) ? ST_UNDER : ST_OK);

  always_comb begin
    emit_o.valid             = (state_q == S_EMIT);
    emit_o.data.status       = emit_status;
    emit_o.data.result_value = (emit_status == ST_OK) ? top_q : '0;
  end

  always_comb begin
    err_d = err_q;
    if ((state_q == S_EMIT) && emit_ready_i) begin
      err_d = ST_OK;
    end else if (flag_en && (err_q == ST_OK)) begin
      err_d = flag_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q    <= '0;
      err_q   <= ST_OK;
      vval_q  <= '0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      err_q   <= err_d;
      if (vwr_en) begin
        vval_q[vaddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (in_acc) begin
      req_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stk_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= stk_q[sp_m2[ADDR_W-1:0]];
      rd_b_q <= stk_q[sp_m1[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vwr_en) begin
      var_q[vaddr] <= in_data_i.operand_value;
    end
    if (vrd_en) begin
      vrd_q    <= var_q[vaddr];
      vrd_ok_q <= vin_range && vval_q[vaddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/postfix_expression_evaluator.sv */
`default_nettype none

// Postfix integer expression evaluator with an operand stack and a variable store.
// Requests enter on in_valid_i / in_stall_o / in_data_i and are taken at an edge where
// valid is high and stall is low. A load request writes a variable slot; a token request
// pushes a constant or a variable, or applies add, subtract, multiply or divide to the
// two top stack entries. A token marked last produces one result on out_valid_o /
// out_stall_i / out_data_o (top of stack and status), then the stack is cleared.
// Add, subtract, multiply and divide run in the shared arithmetic unit, whose radix-2
// divider retires one quotient bit per cycle. A last token then enters the emit state,
// which hands its result to the output register once that register can take it.
// The output register lets the next request enter while a result waits; a second
// result waits in the sequencer until the receiver drops stall.
// Reset clears the stack pointer, the error status and the variable store, which then
// reads as zero; reset takes effect at once and the block is ready after it.

module postfix_expression_evaluator
  import rpn_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  emit_t    emit;
  logic     emit_ready;

  logic out_valid_q;
  out_t out_q;

  rpn_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .alu_req_o    (alu_req),
    .alu_rsp_i    (alu_rsp),
    .emit_o       (emit),
    .emit_ready_i (emit_ready)
  );

  rpn_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign emit_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid && emit_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid && emit_ready) begin
      out_q <= emit.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* rtl/rpn_checker.sv */
`default_nettype none

module rpn_checker
  import rpn_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire in_t  in_data_i,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_data_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Any error status carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> (out_data_o.result_value == '0))
    else $error("error result with nonzero value");

  // A load finishes in the cycle it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.action == ACT_LOAD) |=> !in_stall_o)
    else $error("block busy after a load request");

  // A push of a variable needs a store read, so the block is busy next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.action == ACT_PUSH_VAR) |=> in_stall_o)
    else $error("block ready during a variable fetch");

endmodule

bind postfix_expression_evaluator rpn_checker u_rpn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rpn_pkg::*;

  localparam int RESET_CYCLES   = 11;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_REQUESTS = 375;
  localparam int PRINT_LIMIT    = 50;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  postfix_expression_evaluator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Evaluator state as the testbench sees it.
  logic [DATA_W-1:0] eval_stack [STACK_DEPTH];
  int                eval_depth;
  logic [DATA_W-1:0] var_file [VAR_COUNT];
  status_e           sticky_status;
  out_t              expected_results [$];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_pending;
  int hold_left;

  int requests_sent;
  int results_checked;
  int mismatch_count;
  int status_count [4];
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
  endtask

  function automatic void note_error(status_e code);
    if (sticky_status == ST_OK) begin
      sticky_status = code;
    end
  endfunction

  function automatic void push_operand(logic [DATA_W-1:0] value);
    if (eval_depth >= STACK_DEPTH) begin
      note_error(ST_OVER);
    end else begin
      eval_stack[eval_depth] = value;
      eval_depth++;
    end
  endfunction

  // Updates the evaluator state for one request and queues the result of a last token.
  task automatic evaluate_request(in_t req);
    logic [DATA_W-1:0]          lhs;
    logic [DATA_W-1:0]          rhs;
    logic [DATA_W-1:0]          res;
    logic signed [2*DATA_W-1:0] num;
    logic signed [2*DATA_W-1:0] den;
    logic signed [2*DATA_W-1:0] quo;
    out_t                       want;
    if (req.action == ACT_LOAD) begin
      if (req.var_index < VAR_COUNT) begin
        var_file[req.var_index] = req.operand_value;
      end
      return;
    end
    case (req.action)
      ACT_PUSH_CONST: push_operand(req.operand_value);
      ACT_PUSH_VAR: begin
        push_operand((req.var_index < VAR_COUNT) ? var_file[req.var_index] : '0);
      end
      default: begin
        if (eval_depth < 2) begin
          note_error(ST_UNDER);
        end else begin
          lhs = eval_stack[eval_depth-2];
          rhs = eval_stack[eval_depth-1];
          case (req.operator_code)
            OP_ADD: res = lhs + rhs;
            OP_SUB: res = lhs - rhs;
            OP_MUL: res = lhs * rhs;
            default: begin
              if (rhs == '0) begin
                note_error(ST_DIVZ);
                res = '0;
              end else begin
                // Widened signed division truncates toward zero, and the most
                // negative value over minus one wraps back to itself.
                num = {{DATA_W{lhs[DATA_W-1]}}, lhs};
                den = {{DATA_W{rhs[DATA_W-1]}}, rhs};
                quo = num / den;
                res = quo[DATA_W-1:0];
              end
            end
          endcase
          eval_stack[eval_depth-2] = res;
          eval_depth--;
        end
      end
    endcase
    if (!req.last) begin
      return;
    end
    if (eval_depth == 0) begin
      note_error(ST_UNDER);
    end
    want.status       = sticky_status;
    want.result_value = (sticky_status == ST_OK) ? eval_stack[eval_depth-1] : '0;
    expected_results = {expected_results, want};
    status_count[sticky_status]++;
    eval_depth    = 0;
    sticky_status = ST_OK;
  endtask

  // Offers one request and returns at the edge that accepts it.
  task automatic send_request(in_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    evaluate_request(req);
    requests_sent++;
  endtask

  task automatic send_token(action_e act, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value,
                            op_e op, bit last);
    in_t req;
    req.action        = act;
    req.var_index     = idx;
    req.operand_value = value;
    req.operator_code = op;
    req.last          = last;
    send_request(req);
  endtask

  function automatic in_t random_request();
    in_t req;
    req.action        = action_e'($urandom_range(0, 3));
    req.var_index     = IDX_W'($urandom_range(0, 31));
    req.operand_value = $urandom;
    req.operator_code = op_e'($urandom_range(0, 3));
    req.last          = 1'($urandom_range(0, 1));
    return req;
  endfunction

  // Leans on zero, the extremes and small values so that division corners come up.
  function automatic logic [DATA_W-1:0] random_operand();
    logic [DATA_W-1:0] value;
    case ($urandom_range(0, 9))
      0: value = '0;
      1: value = 32'h8000_0000;
      2: value = 32'h7fff_ffff;
      3: value = 32'hffff_ffff;
      4, 5: begin
        value = $urandom_range(1, 20);
        if ($urandom_range(0, 1)) begin
          value = -value;
        end
      end
      default: value = $urandom;
    endcase
    return value;
  endfunction

  // A well-formed expression with the given number of operands, loads mixed in.
  task automatic run_expression(int operand_count);
    in_t req;
    int  depth;
    int  pushed;
    depth  = 0;
    pushed = 0;
    while (pushed < operand_count || depth > 1) begin
      if ($urandom_range(0, 7) == 0) begin
        req               = random_request();
        req.action        = ACT_LOAD;
        req.operand_value = random_operand();
        send_request(req);
      end
      req = random_request();
      if (pushed < operand_count && (depth < 2 || $urandom_range(0, 1))) begin
        req.action        = ($urandom_range(0, 2) == 0) ? ACT_PUSH_VAR : ACT_PUSH_CONST;
        req.operand_value = random_operand();
        pushed++;
        depth++;
      end else begin
        req.action = ACT_APPLY;
        depth--;
      end
      req.last = (pushed == operand_count && depth == 1);
      send_request(req);
    end
  endtask

  task automatic run_noise(int count);
    in_t req;
    repeat (count) begin
      req      = random_request();
      req.last = ($urandom_range(0, 3) == 0);
      send_request(req);
    end
  endtask

  task automatic test_directed_cases();
    // A load marked last must not produce a result.
    send_token(ACT_LOAD, 5'd0, 32'h7fff_ffff, OP_ADD, 1'b0);
    send_token(ACT_LOAD, 5'd31, 32'h8000_0000, OP_DIV, 1'b1);
    send_token(ACT_PUSH_VAR, 5'd0, 32'h0, OP_MUL, 1'b0);
    send_token(ACT_PUSH_VAR, 5'd31, 32'hffff_ffff, OP_SUB, 1'b0);
    send_token(ACT_APPLY, 5'd0, 32'h0, OP_ADD, 1'b1);
    send_token(ACT_PUSH_CONST, 5'd0, 32'h8000_0000, OP_ADD, 1'b0);
    send_token(ACT_PUSH_CONST, 5'd31, 32'hffff_ffff, OP_ADD, 1'b0);
    send_token(ACT_APPLY, 5'd0, 32'h0, OP_DIV, 1'b1);
    // Divide by zero stays the reported error even after a later underflow.
    send_token(ACT_PUSH_CONST, 5'd0, 32'd7, OP_ADD, 1'b0);
    send_token(ACT_PUSH_CONST, 5'd0, 32'd0, OP_ADD, 1'b0);
    send_token(ACT_APPLY, 5'd0, 32'h0, OP_DIV, 1'b0);
    send_token(ACT_APPLY, 5'd0, 32'h0, OP_MUL, 1'b0);
    send_token(ACT_PUSH_CONST, 5'd0, 32'd5, OP_ADD, 1'b1);
    send_token(ACT_APPLY, 5'd0, 32'h0, OP_SUB, 1'b1);
    send_token(ACT_PUSH_CONST, 5'd0, -32'sd7, OP_ADD, 1'b0);
    send_token(ACT_PUSH_CONST, 5'd0, 32'd2, OP_ADD, 1'b0);
    send_token(ACT_APPLY, 5'd0, 32'h0, OP_DIV, 1'b1);
    // Leftover entries: only the top is reported.
    send_token(ACT_PUSH_CONST, 5'd0, 32'd1, OP_ADD, 1'b0);
    send_token(ACT_PUSH_CONST, 5'd0, 32'd2, OP_ADD, 1'b0);
    send_token(ACT_PUSH_CONST, 5'd0, 32'd3, OP_ADD, 1'b1);
    send_token(ACT_PUSH_CONST, 5'd0, 32'h0001_0000, OP_ADD, 1'b0);
    send_token(ACT_PUSH_CONST, 5'd0, 32'h0001_0000, OP_ADD, 1'b0);
    send_token(ACT_APPLY, 5'd0, 32'h0, OP_MUL, 1'b1);
  endtask

  task automatic test_stack_limits();
    run_expression(STACK_DEPTH);
    run_expression(STACK_DEPTH + 1);
    run_expression(STACK_DEPTH + 8);
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct);
    int start;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start         = requests_sent;
    while (requests_sent - start < PHASE_REQUESTS) begin
      case ($urandom_range(0, 19))
        0: run_expression($urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 4));
        1, 2, 3: run_noise($urandom_range(1, 6));
        default: run_expression($urandom_range(1, 8));
      endcase
    end
  endtask

  // The receiver holds off while short expressions keep coming, so the block backs up.
  task automatic test_output_backpressure();
    hold_pending = 1'b1;
    repeat (25) begin
      run_expression($urandom_range(1, 2));
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d with no expression pending",
                                  out_data_o.result_value));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_data_o.result_value !== want.result_value) begin
          report_mismatch($sformatf("result_value %0d, expected %0d",
                                    out_data_o.result_value, want.result_value));
        end
        if (out_data_o.status !== want.status) begin
          report_mismatch($sformatf("status %s, expected %s",
                                    out_data_o.status.name(), want.status.name()));
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timed out after %0d cycles without a handshake.", WATCHDOG_LIMIT);
    $display("postfix_expression_evaluator regression: fail");
    $finish;
  end

  initial begin
    foreach (var_file[i]) begin
      var_file[i] = '0;
    end
    eval_depth    = 0;
    sticky_status = ST_OK;
    send_idle_pct = 27;
    recv_idle_pct = 56;
    hold_pending  = 1'b0;
    hold_left     = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_traffic(27, 56);
    test_stack_limits();
    test_random_traffic(56, 27);
    test_random_traffic(0, 0);
    test_output_backpressure();
    in_valid_i <= 1'b0;

    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end

    $display("Sent %0d requests under three idle mixes and a long output hold-off;",
             requests_sent);
    $display("%0d results checked.", results_checked);
    $display("Result statuses: ok %0d, underflow %0d, overflow %0d, divide by zero %0d.",
             status_count[ST_OK], status_count[ST_UNDER], status_count[ST_OVER],
             status_count[ST_DIVZ]);
    if (mismatch_count == 0) begin
      $display("postfix_expression_evaluator regression: pass");
    end else begin
      $display("%0d mismatches.", mismatch_count);
      $display("postfix_expression_evaluator regression: fail");
    end
    $finish;
  end

endmodule
